FILE: src/lbb_pkg.sv
// Shared constants, types and helper functions of the LRU byte buffer.
package lbb_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int KEY_W       = 8;
  localparam int OCC_W       = 5;
  localparam int TOT_W       = 32;

  localparam logic [OCC_W-1:0] CAPACITY_RESET = OCC_W'(10);
  localparam logic [OCC_W-1:0] OCC_MAX        = OCC_W'(MAX_ENTRIES);
  localparam logic [TOT_W-1:0] TOT_MAX        = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture the accepted request's key.
    logic lookup;  // Compare the key against the held entries.
    logic commit;  // Update the entry row and counters, load the result.
  } lbb_cmd_t;

  function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
    sat_inc = (v == TOT_MAX) ? v : v + TOT_W'(1);
  endfunction

endpackage

FILE: src/lbb_ifs.sv
// Channel interfaces for requests, results and the capacity register.
interface lbb_in_if
  import lbb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface lbb_out_if
  import lbb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted_valid;
  logic [KEY_W-1:0] evicted_key;
  logic [OCC_W-1:0] occupancy;
  logic [TOT_W-1:0] hit_total;
  logic [TOT_W-1:0] miss_total;
  logic [TOT_W-1:0] access_total;

  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  output occupancy, output hit_total, output miss_total,
                  output access_total, input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
                  input occupancy, input hit_total, input miss_total,
                  input access_total, output ready);
endinterface

interface lbb_cfg_if
  import lbb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OCC_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

FILE: src/lru_byte_buffer_top.sv
// Top level of the LRU byte buffer: controller, datapath and channel ports.
//
//  Channel  Direction  Payload                                         Handshake
//  in_if    sink       key[7:0]                                        valid/ready
//  out_if   source     hit, evicted_valid, evicted_key[7:0],           valid/ready
//                      occupancy[4:0], hit/miss/access_total[31:0]
//  cfg_if   sink       capacity[4:0]                                   valid/ready
//
// Each request passes through the accept edge, a lookup step in which the
// key is compared against all sixteen entries in parallel and the matching
// position is registered, and an update step in which the entry row shifts and the
// counters and result register are loaded. A new request is accepted only after the
// update step of the last one is done. The result register sits between
// the update step and out_if, so the next request is taken while a result
// still waits; a stalled result holds the update step until the sink takes it.
// Reset (rst_n low, synchronous) empties the buffer, clears the counters and
// sets capacity to 10. The capacity register always accepts writes.
module lru_byte_buffer_top
  import lbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lbb_in_if.sink     in_if,
  lbb_out_if.source  out_if,
  lbb_cfg_if.sink    cfg_if
);

  lbb_cmd_t cmd;

  // The capacity register can be written in any cycle.
  assign cfg_if.ready = 1'b1;

  // The controller only sequences; all payload lives in the datapath.
  lbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // The datapath keeps entries with the oldest at position zero and the
  // most recent at the top of the occupied range.
  lbb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_key            (in_if.key),
    .cfg_valid         (cfg_if.valid),
    .cfg_capacity      (cfg_if.capacity),
    .res_hit           (out_if.hit),
    .res_evicted_valid (out_if.evicted_valid),
    .res_evicted_key   (out_if.evicted_key),
    .res_occupancy     (out_if.occupancy),
    .res_hit_total     (out_if.hit_total),
    .res_miss_total    (out_if.miss_total),
    .res_access_total  (out_if.access_total)
  );

endmodule

FILE: src/lbb_ctrl.sv
// Controller state machine that sequences lookup and update of one request.
module lbb_ctrl
  import lbb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lbb_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_ready && in_valid;
    cmd.lookup = (state_r == S_LOOK);
    cmd.commit = (state_r == S_UPD) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The result register frees up as soon as the sink takes it.
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.load) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_LOOK))
    else $error("accepted request did not start a lookup");

  a_lookup_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |=> (state_r == S_UPD))
    else $error("lookup not followed by update");

endmodule

FILE: src/lbb_dp.sv
// Datapath: entry row in recency order, parallel compare, counters, result register.
module lbb_dp
  import lbb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lbb_cmd_t         cmd,
  input  logic [KEY_W-1:0] in_key,
  input  logic             cfg_valid,
  input  logic [OCC_W-1:0] cfg_capacity,
  output logic             res_hit,
  output logic             res_evicted_valid,
  output logic [KEY_W-1:0] res_evicted_key,
  output logic [OCC_W-1:0] res_occupancy,
  output logic [TOT_W-1:0] res_hit_total,
  output logic [TOT_W-1:0] res_miss_total,
  output logic [TOT_W-1:0] res_access_total
);

  logic [KEY_W-1:0] keys_r [MAX_ENTRIES];
  logic [KEY_W-1:0] keys_nxt [MAX_ENTRIES];
  logic [OCC_W-1:0] count_r, count_nxt;
  logic [OCC_W-1:0] cap_r;
  logic [KEY_W-1:0] key_r;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] found_r, found_nxt;
  logic [TOT_W-1:0] hit_tot_r, hit_tot_nxt;
  logic [TOT_W-1:0] miss_tot_r, miss_tot_nxt;
  logic [TOT_W-1:0] acc_tot_r, acc_tot_nxt;

  logic             res_hit_r, res_ev_valid_r;
  logic [KEY_W-1:0] res_ev_key_r;
  logic [OCC_W-1:0] res_occ_r;

  logic [OCC_W-1:0] eff_cap;
  logic             evict;
  logic             remove;
  logic [IDX_W-1:0] rm_pos;
  logic [OCC_W-1:0] count_after;

  // Lookup: compare all held positions at once; the lowest match wins.
  always_comb begin
    hit_nxt   = 1'b0;
    found_nxt = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if ((keys_r[i] == key_r) && (OCC_W'(i) < count_r)) begin
        hit_nxt   = 1'b1;
        found_nxt = IDX_W'(i);
      end
    end
  end

  // Update: on a hit or an eviction drop one position and close the gap; append the key as most recent.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_r > OCC_MAX) begin
      eff_cap = OCC_MAX;
    end else begin
      eff_cap = cap_r;
    end
    evict       = !hit_r && (count_r >= eff_cap) && (count_r != '0);
    remove      = hit_r || evict;
    rm_pos      = hit_r ? found_r : '0;
    count_after = remove ? count_r - OCC_W'(1) : count_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      keys_nxt[i] = keys_r[i];
    end
    for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
      if (remove && (IDX_W'(i) >= rm_pos)) begin
        keys_nxt[i] = keys_r[i + 1];
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if ((count_after < OCC_MAX) && (OCC_W'(i) == count_after)) begin
        keys_nxt[i] = key_r;
      end
    end
    count_nxt    = (count_after < OCC_MAX) ? count_after + OCC_W'(1) : count_after;
    acc_tot_nxt  = sat_inc(acc_tot_r);
    hit_tot_nxt  = hit_r ? sat_inc(hit_tot_r) : hit_tot_r;
    miss_tot_nxt = hit_r ? miss_tot_r : sat_inc(miss_tot_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      cap_r      <= CAPACITY_RESET;
      hit_tot_r  <= '0;
      miss_tot_r <= '0;
      acc_tot_r  <= '0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_capacity;
      end
      if (cmd.commit) begin
        count_r    <= count_nxt;
        hit_tot_r  <= hit_tot_nxt;
        miss_tot_r <= miss_tot_nxt;
        acc_tot_r  <= acc_tot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
    end
    if (cmd.lookup) begin
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
    end
    if (cmd.commit) begin
      keys_r         <= keys_nxt;
      res_hit_r      <= hit_r;
      res_ev_valid_r <= evict;
      res_ev_key_r   <= evict ? keys_r[0] : '0;
      res_occ_r      <= count_nxt;
    end
  end

  assign res_hit           = res_hit_r;
  assign res_evicted_valid = res_ev_valid_r;
  assign res_evicted_key   = res_ev_key_r;
  assign res_occupancy     = res_occ_r;
  assign res_hit_total     = hit_tot_r;
  assign res_miss_total    = miss_tot_r;
  assign res_access_total  = acc_tot_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= OCC_MAX)
    else $error("entry count above the row size");

endmodule
